// ===== hdl/plstat_pkg.sv =====
// Shared types and constants for the per-label channel statistics block.
`timescale 1ns / 1ps
`default_nettype none
package plstat_pkg;
  localparam int MEAN_W = 16;
  localparam int VAR_W  = 32;

  // Word kinds on the input tuser.
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Control from the sequencer to one lane.
  typedef struct packed {
    logic rd_en;     // read this lane's sums at the given address
    logic acc_en;    // write back the updated sums
    logic zero_old;  // label was empty, stored sums are stale
    logic start;     // begin the mean and variance computation
  } lane_ctrl_t;

  // Finished statistics of one lane.
  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
  } lane_res_t;
endpackage
`default_nettype wire

// ===== hdl/plstat_div.sv =====
// Restoring divider that resolves one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module plstat_div #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_sh   = {rem_r, q_r[NUM_W-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

// ===== hdl/plstat_lane.sv =====
// One channel lane: sum and square-sum memories plus the mean and variance unit.
`timescale 1ns / 1ps
`default_nettype none
module plstat_lane #(
  parameter int AW          = 12,
  parameter int LABEL_COUNT = 4096,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire plstat_pkg::lane_ctrl_t ctrl,
  input  wire logic [AW-1:0]          addr,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [COUNT_BITS-1:0]  n,
  output logic                        done,
  output plstat_pkg::lane_res_t       res
);
  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int PR_W  = 2 * SUM_W;
  localparam int MCW   = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {L_IDLE, L_MEAN, L_MUL, L_SQDIV, L_VAR} lstate_t;

  logic [SUM_W-1:0] sum_mem [LABEL_COUNT];
  logic [SQ_W-1:0]  sq_mem  [LABEL_COUNT];
  logic [SUM_W-1:0] sum_rd_r;
  logic [SQ_W-1:0]  sq_rd_r;
  logic [SUM_W-1:0] sum_old;
  logic [SQ_W-1:0]  sq_old;

  lstate_t          st_r;
  logic [SUM_W-1:0] s_r;
  logic [SQ_W-1:0]  s2_r;
  logic [COUNT_BITS-1:0] n_r;
  logic [PR_W-1:0]  acc_r;
  logic [SUM_W-1:0] m_r;
  logic [MCW-1:0]   mc_r;
  logic             done_r;
  plstat_pkg::lane_res_t res_r;

  logic             dv_start;
  logic [PR_W-1:0]  dv_num;
  logic [COUNT_BITS-1:0] dv_den;
  logic             dv_done;
  logic [PR_W-1:0]  dv_quo;
  logic [SQ_W-1:0]  diff;

  // A label that was empty has stale sums, so it starts again from zero.
  assign sum_old = ctrl.zero_old ? '0 : sum_rd_r;
  assign sq_old  = ctrl.zero_old ? '0 : sq_rd_r;

  // Sum memories: one registered read, one write.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      sum_rd_r <= sum_mem[addr];
      sq_rd_r  <= sq_mem[addr];
    end
    if (ctrl.acc_en) begin
      sum_mem[addr] <= sum_old + SUM_W'(sample);
      sq_mem[addr]  <= sq_old + SQ_W'(sample) * SQ_W'(sample);
    end
  end

  // The square-over-count term is capped at the square sum.
  assign diff = ({{(PR_W-SQ_W){1'b0}}, s2_r} >= dv_quo) ?
                SQ_W'({{(PR_W-SQ_W){1'b0}}, s2_r} - dv_quo) : '0;

  // Divider operands for each step of the sequence.
  always_comb begin
    dv_start = 1'b0;
    dv_num   = PR_W'(s_r);
    dv_den   = n_r;
    case (st_r)
      L_IDLE: begin
        dv_start = ctrl.start;
        dv_num   = PR_W'(sum_rd_r);
        dv_den   = n;
      end
      L_MUL: begin
        dv_start = (mc_r == '0);
        dv_num   = acc_r;
      end
      L_SQDIV: begin
        dv_start = dv_done;
        dv_num   = PR_W'(diff);
        dv_den   = n_r - 1'b1;
      end
      default: ;
    endcase
  end

  plstat_div #(.NUM_W(PR_W), .DEN_W(COUNT_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // Sequence: mean, square of the sum, its quotient, then the variance; one pixel stops after the mean.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (ctrl.start) begin
            s_r  <= sum_rd_r;
            s2_r <= sq_rd_r;
            n_r  <= n;
            st_r <= L_MEAN;
          end
        end
        L_MEAN: begin
          if (dv_done) begin
            res_r.mean     <= plstat_pkg::MEAN_W'(dv_quo);
            res_r.variance <= '0;
            if (n_r == COUNT_BITS'(1)) begin
              done_r <= 1'b1;
              st_r   <= L_IDLE;
            end else begin
              acc_r <= '0;
              m_r   <= s_r;
              mc_r  <= MCW'(SUM_W);
              st_r  <= L_MUL;
            end
          end
        end
        L_MUL: begin
          if (mc_r == '0) begin
            st_r <= L_SQDIV;
          end else begin
            acc_r <= {acc_r[PR_W-2:0], 1'b0} + (m_r[SUM_W-1] ? PR_W'(s_r) : '0);
            m_r   <= {m_r[SUM_W-2:0], 1'b0};
            mc_r  <= mc_r - 1'b1;
          end
        end
        L_SQDIV: begin
          if (dv_done) st_r <= L_VAR;
        end
        L_VAR: begin
          if (dv_done) begin
            res_r.variance <= (|dv_quo[PR_W-1:plstat_pkg::VAR_W]) ?
                              '1 : dv_quo[plstat_pkg::VAR_W-1:0];
            done_r <= 1'b1;
            st_r   <= L_IDLE;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire

// ===== hdl/per_label_channel_statistics.sv =====
// Top level of the per-label channel statistics block.
//
// Words are handled one at a time. An accumulate word is accepted with the
// registered memory read and then written back. A readout is accepted, reads
// the memories and then, when the label holds pixels, runs one 2*SUM_W-bit
// serial division for one pixel, or three such divisions and one SUM_W-step
// serial squaring for more (SUM_W = SAMPLE_BITS + COUNT_BITS), followed by one
// result word per active channel, each held until it is taken. All lanes run
// the same sequence side by side. After reset a clearing pass over every label
// address zeroes the count memory; no word is accepted during it.
`timescale 1ns / 1ps
`default_nettype none
module per_label_channel_statistics #(
  parameter int LABEL_COUNT = 4096,
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_wdata,   // active_channels
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,    // label, sample_ch0..sample_ch3, zero pad
  input  wire logic        in_tuser,    // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,   // out_label, channel_index, pixel_count,
                                        // mean_value, variance_value, zero pad
  output logic             out_tuser,   // empty_label
  output logic             out_tlast    // last_channel
);
  localparam int AW     = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
  localparam int NLANES = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int LW     = (NLANES > 1) ? $clog2(NLANES) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CALC, S_OUT} state_t;

  state_t                st_r;
  logic [AW-1:0]         clr_r;
  logic [2:0]            act_r;
  logic [2:0]            nch;
  logic [COUNT_BITS-1:0] cnt_mem [LABEL_COUNT];
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic                  op_r;
  logic [11:0]           label_r;
  logic                  inr_r;
  logic [AW-1:0]         addr_r;
  logic [15:0]           samp_r [4];
  logic [COUNT_BITS-1:0] n_r;
  logic [2:0]            ch_r;
  logic                  accept;
  logic [20:0]           label_ext;
  logic                  in_rng;
  logic [AW-1:0]         addr_in;
  logic [AW-1:0]         addr_mem;
  logic                  do_acc;
  logic [NLANES-1:0]     lane_done;
  plstat_pkg::lane_ctrl_t lane_ctrl [NLANES];
  plstat_pkg::lane_res_t  lane_res  [NLANES];
  plstat_pkg::lane_res_t  cur_res;
  logic                  empty;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign label_ext = {9'd0, in_tdata[11:0]};
  assign in_rng    = (label_ext < 21'(LABEL_COUNT));
  assign addr_in   = label_ext[AW-1:0];
  assign addr_mem  = accept ? addr_in : addr_r;

  // Effective channel count: zero acts as one, capped by the lanes built.
  assign nch = (act_r == 3'd0) ? 3'd1 :
               ((act_r > 3'(NLANES)) ? 3'(NLANES) : act_r);

  assign do_acc = (st_r == S_READ) && (op_r == plstat_pkg::OP_ACCUM) && inr_r &&
                  (cnt_rd_r != CNT_MAX);

  // Count memory, cleared by the pass after reset.
  always_ff @(posedge clk) begin
    if (st_r == S_CLEAR) cnt_mem[clr_r] <= '0;
    else if (do_acc) cnt_mem[addr_r] <= cnt_rd_r + 1'b1;
    if (accept) cnt_rd_r <= cnt_mem[addr_in];
  end

  // Lanes, one per channel. Every lane writes back on an accumulate; an
  // inactive lane adds zero, so its sums stay defined for a nonempty label.
  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    always_comb begin
      lane_ctrl[g].rd_en    = accept;
      lane_ctrl[g].acc_en   = do_acc;
      lane_ctrl[g].zero_old = (cnt_rd_r == '0);
      lane_ctrl[g].start    = (st_r == S_READ) && (op_r == plstat_pkg::OP_READ) &&
                              inr_r && (cnt_rd_r != '0);
    end
    plstat_lane #(
      .AW(AW), .LABEL_COUNT(LABEL_COUNT),
      .SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl[g]),
      .addr   (addr_mem),
      .sample ((3'(g) < nch) ? samp_r[g][SAMPLE_BITS-1:0] : '0),
      .n      (cnt_rd_r),
      .done   (lane_done[g]),
      .res    (lane_res[g])
    );
  end

  // Sequencer with the configuration register and the word latches.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      clr_r <= '0;
      act_r <= 3'd4;
      ch_r  <= '0;
    end else begin
      if (cfg_wen) act_r <= cfg_wdata;
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(LABEL_COUNT - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) st_r <= S_READ;
        end
        S_READ: begin
          ch_r <= '0;
          if (op_r == plstat_pkg::OP_ACCUM) st_r <= S_IDLE;
          else if (inr_r && (cnt_rd_r != '0)) st_r <= S_CALC;
          else st_r <= S_OUT;
        end
        S_CALC: begin
          if (lane_done[0]) st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            ch_r <= ch_r + 1'b1;
            if (out_tlast) st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
    if (accept) begin
      op_r      <= in_tuser;
      label_r   <= in_tdata[11:0];
      inr_r     <= in_rng;
      addr_r    <= addr_in;
      samp_r[0] <= in_tdata[27:12] & 16'((1 << SAMPLE_BITS) - 1);
      samp_r[1] <= in_tdata[43:28] & 16'((1 << SAMPLE_BITS) - 1);
      samp_r[2] <= in_tdata[59:44] & 16'((1 << SAMPLE_BITS) - 1);
      samp_r[3] <= in_tdata[75:60] & 16'((1 << SAMPLE_BITS) - 1);
    end
    if (st_r == S_READ) n_r <= inr_r ? cnt_rd_r : '0;
  end

  // Result word for the current channel.
  assign cur_res    = lane_res[ch_r[LW-1:0]];
  assign empty      = (n_r == '0);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tuser  = empty;
  assign out_tlast  = ((ch_r + 3'd1) == nch);
  assign out_tdata  = {2'b00,
                       empty ? 32'd0 : cur_res.variance,
                       empty ? 16'd0 : cur_res.mean,
                       24'(n_r),
                       ch_r[1:0],
                       label_r};

  // Results only appear while no input word can be taken.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input ready while a result is shown");

  // An empty label reports zero statistics.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[85:38] == 48'd0))
    else $error("empty label with nonzero statistics");

  // Channel index never runs past the active channel count.
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ch_r < nch))
    else $error("channel index beyond active channels");

  // The sequencer leaves the clearing pass only after the full sweep.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(st_r) == S_CLEAR && st_r == S_IDLE) |-> ($past(clr_r) == AW'(LABEL_COUNT - 1)))
    else $error("clearing pass ended early");
endmodule
`default_nettype wire
